// ----- sv/kgm_pkg.sv -----
// Shared constants, field widths and codes for the keypoint greedy matcher.
package kgm_pkg;

    localparam int MAX_FEATS = 64;
    localparam int MAX_DESC  = 128;

    localparam int FEAT_W  = $clog2(MAX_FEATS);
    localparam int ELEM_W  = $clog2(MAX_DESC);
    localparam int PAIR_W  = 2 * FEAT_W;
    localparam int DADDR_W = FEAT_W + ELEM_W;
    localparam int CNT_W   = 7;
    localparam int DLEN_W  = 8;
    localparam int RAD_W   = 35;
    localparam int SQ_W    = 34;
    localparam int DIST2_W = 40;
    localparam int ROOT_W  = 20;
    localparam int RANK_W  = 6;
    localparam int POS_W   = 16;

    // Item kinds carried on the input tuser
    localparam logic [1:0] FUNC_LOAD_POS  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_DESC = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE   = 2'd2;
    localparam logic [1:0] FUNC_READ      = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_NFIRST = 2'd1;
    localparam logic [1:0] CFG_NSECND = 2'd2;
    localparam logic [1:0] CFG_DLEN   = 2'd3;

    // Pair flag word: in radius, position match, descriptor match, rank
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              desc;
        logic              pos;
        logic              in_rad;
    } flags_t;

    localparam int FLAG_W = $bits(flags_t);

    // Square-root unit handshake
    typedef struct packed {
        logic start;
        logic done;
    } sqrt_ctl_t;

endpackage

// ----- sv/kgm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/kgm_sqr.sv -----
// Shared squared-difference unit: registers (a - b)^2 of two signed words.
module kgm_sqr (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [kgm_pkg::POS_W-1:0] a,
    input  logic signed [kgm_pkg::POS_W-1:0] b,
    output logic [kgm_pkg::SQ_W-1:0]      sq
);

    logic signed [kgm_pkg::POS_W:0]    diff;
    logic signed [kgm_pkg::SQ_W-1:0]   prod;
    logic [kgm_pkg::SQ_W-1:0]          sq_reg;

    // Widen before subtracting so the difference never wraps
    assign diff = {a[kgm_pkg::POS_W-1], a} - {b[kgm_pkg::POS_W-1], b};
    assign prod = diff * diff;

    // Hold the product for the sequencer
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= $unsigned(prod);
        end
    end

    assign sq = sq_reg;

endmodule

// ----- sv/kgm_isqrt.sv -----
// Bit-serial floor square root, two radicand bits per cycle.
module kgm_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [kgm_pkg::DIST2_W-1:0]    value,
    output logic                           done,
    output logic [kgm_pkg::ROOT_W-1:0]     root
);

    localparam int REM_W = kgm_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(kgm_pkg::ROOT_W + 1);

    logic [kgm_pkg::DIST2_W-1:0] val_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [kgm_pkg::ROOT_W-1:0]  root_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        run_reg;
    logic                        done_reg;
    logic [REM_W+1:0]            rem_sh;
    logic [REM_W+1:0]            trial;
    logic                        take;

    assign rem_sh = {rem_reg, val_reg[kgm_pkg::DIST2_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    // Restore one root bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                val_reg  <= value;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(kgm_pkg::ROOT_W);
                run_reg  <= 1'b1;
                done_reg <= 1'b0;
            end else if (run_reg) begin
                val_reg <= {val_reg[kgm_pkg::DIST2_W-3:0], 2'b00};
                if (take) begin
                    rem_reg  <= REM_W'(rem_sh - trial);
                    root_reg <= {root_reg[kgm_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= REM_W'(rem_sh);
                    root_reg <= {root_reg[kgm_pkg::ROOT_W-2:0], 1'b0};
                end
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- sv/keypoint_greedy_matcher_unit.sv -----
// Top level: keypoint stores, pair table, sequencer and result register.
//
// Input stream (s_axis_*): tuser selects the transaction kind (load position,
// load descriptor element, compute, read pair) and the keypoint set; tdata
// carries indices, position and descriptor element. Loads may follow one
// another back to back and return nothing. A compute transaction fills the
// pair table, runs greedy position matching, then greedy descriptor
// matching, and returns one transaction with tuser set; if either keypoint
// count is zero it skips straight to that result. Pair entries are
// computed one after another through the shared squarer, and descriptor
// matching rescans the pair table through its single read address once per
// match. A read transaction returns one pair's flags, descriptor distance
// and rank once the bit-serial square root has finished.
// s_axis_tready is high only while the sequencer is idle. Results sit in an
// output register; a stalled receiver holds the sequencer in its last step
// until the register frees. Reset (aresetn, synchronous) restores the
// configuration registers and clears the sequencer; keypoint and pair
// memories are not cleared. Configuration writes are taken at any time.
module keypoint_greedy_matcher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [34:0] cfg_wr_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: feat_index[5:0], col_index[11:6], elem_index[18:12],
    //        pos_x[34:19], pos_y[50:35], desc_value[66:51], zero fill
    input  logic [71:0] s_axis_tdata,
    // tuser: func[1:0], side[2]
    input  logic [2:0]  s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: row_index[5:0], pair_col[11:6], in_radius[12], pos_matched[13],
    //        desc_distance[33:14], desc_matched[34], desc_rank[40:35], zero fill
    output logic [47:0] m_axis_tdata,
    // tuser: done_res[0]
    output logic        m_axis_tuser
);

    localparam int FW = kgm_pkg::FEAT_W;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_POS_A   = 5'd1;
    localparam logic [4:0] ST_POS_X   = 5'd2;
    localparam logic [4:0] ST_POS_Y   = 5'd3;
    localparam logic [4:0] ST_POS_S   = 5'd4;
    localparam logic [4:0] ST_D_RD    = 5'd5;
    localparam logic [4:0] ST_D_MUL   = 5'd6;
    localparam logic [4:0] ST_D_ACC   = 5'd7;
    localparam logic [4:0] ST_PAIR_WR = 5'd8;
    localparam logic [4:0] ST_B_RD    = 5'd9;
    localparam logic [4:0] ST_B_CHK   = 5'd10;
    localparam logic [4:0] ST_C_RD    = 5'd11;
    localparam logic [4:0] ST_C_CMP   = 5'd12;
    localparam logic [4:0] ST_C_FRD   = 5'd13;
    localparam logic [4:0] ST_C_FWR   = 5'd14;
    localparam logic [4:0] ST_R_ADDR  = 5'd15;
    localparam logic [4:0] ST_R_DATA  = 5'd16;
    localparam logic [4:0] ST_R_SQRT  = 5'd17;
    localparam logic [4:0] ST_OUT     = 5'd18;

    // Input fields
    logic [1:0]                 in_func;
    logic                       in_side;
    logic [FW-1:0]              in_feat;
    logic [FW-1:0]              in_col;
    logic [kgm_pkg::ELEM_W-1:0] in_elem;
    logic [15:0]                in_x;
    logic [15:0]                in_y;
    logic [15:0]                in_desc;

    assign in_func = s_axis_tuser[1:0];
    assign in_side = s_axis_tuser[2];
    assign in_feat = s_axis_tdata[5:0];
    assign in_col  = s_axis_tdata[11:6];
    assign in_elem = s_axis_tdata[18:12];
    assign in_x    = s_axis_tdata[34:19];
    assign in_y    = s_axis_tdata[50:35];
    assign in_desc = s_axis_tdata[66:51];

    // Configuration registers
    logic [kgm_pkg::RAD_W-1:0]  radius_reg;
    logic [kgm_pkg::CNT_W-1:0]  nfirst_reg;
    logic [kgm_pkg::CNT_W-1:0]  nsecnd_reg;
    logic [kgm_pkg::DLEN_W-1:0] dlen_reg;

    // Sequencer state
    logic [4:0]                   state_reg;
    logic [kgm_pkg::CNT_W-1:0]    nf_reg;
    logic [kgm_pkg::CNT_W-1:0]    ns_reg;
    logic [kgm_pkg::DLEN_W-1:0]   nd_reg;
    logic [FW-1:0]                j_reg;
    logic [FW-1:0]                i_reg;
    logic [kgm_pkg::DLEN_W-1:0]   v_reg;
    logic [kgm_pkg::SQ_W:0]       d2_reg;
    logic [kgm_pkg::DIST2_W-1:0]  acc_reg;
    logic [kgm_pkg::MAX_FEATS-1:0] row_taken_reg;
    logic [kgm_pkg::MAX_FEATS-1:0] col_taken_reg;
    logic                         found_reg;
    logic [kgm_pkg::DIST2_W-1:0]  best_reg;
    logic [FW-1:0]                bj_reg;
    logic [FW-1:0]                bi_reg;
    logic [kgm_pkg::RANK_W-1:0]   rank_reg;
    logic [FW-1:0]                rd_row_reg;
    logic [FW-1:0]                rd_col_reg;

    // Pending result and output register
    logic                         pend_done_reg;
    kgm_pkg::flags_t              pend_flags_reg;
    logic [kgm_pkg::ROOT_W-1:0]   pend_dist_reg;
    logic                         m_valid_reg;
    logic [47:0]                  m_data_reg;
    logic                         m_user_reg;

    // Memory ports
    logic [31:0]                  pos1_rdata, pos2_rdata;
    logic [15:0]                  desc1_rdata, desc2_rdata;
    logic [kgm_pkg::DIST2_W-1:0]  dist_rdata;
    logic [kgm_pkg::FLAG_W-1:0]   flag_rdata_raw;
    kgm_pkg::flags_t              flag_rdata;
    logic                         pos1_we, pos2_we, desc1_we, desc2_we;
    logic                         dist_we, flag_we;
    logic [kgm_pkg::PAIR_W-1:0]   pair_raddr, flag_waddr;
    kgm_pkg::flags_t              flag_wdata;

    // Shared units
    logic                         sq_en;
    logic signed [15:0]           sq_a, sq_b;
    logic [kgm_pkg::SQ_W-1:0]     sq;
    kgm_pkg::sqrt_ctl_t           sqrt_ctl;
    logic [kgm_pkg::ROOT_W-1:0]   sqrt_root;

    // Scan control
    logic                         last_col, last_row, free_pair;
    logic                         s_fire, out_free;

    assign flag_rdata = kgm_pkg::flags_t'(flag_rdata_raw);
    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign last_col   = ({1'b0, i_reg} + kgm_pkg::CNT_W'(1)) >= ns_reg;
    assign last_row   = ({1'b0, j_reg} + kgm_pkg::CNT_W'(1)) >= nf_reg;
    assign free_pair  = !row_taken_reg[j_reg] && !col_taken_reg[i_reg];

    // Load writes from the input stream
    assign pos1_we  = s_fire && (in_func == kgm_pkg::FUNC_LOAD_POS) && !in_side;
    assign pos2_we  = s_fire && (in_func == kgm_pkg::FUNC_LOAD_POS) && in_side;
    assign desc1_we = s_fire && (in_func == kgm_pkg::FUNC_LOAD_DESC) && !in_side;
    assign desc2_we = s_fire && (in_func == kgm_pkg::FUNC_LOAD_DESC) && in_side;

    // Pair table read address
    always_comb begin
        case (state_reg)
            ST_C_FRD:  pair_raddr = {bj_reg, bi_reg};
            ST_R_ADDR: pair_raddr = {rd_row_reg, rd_col_reg};
            default:   pair_raddr = {j_reg, i_reg};
        endcase
    end

    // Pair table writes
    always_comb begin
        dist_we    = (state_reg == ST_PAIR_WR);
        flag_we    = 1'b0;
        flag_waddr = {j_reg, i_reg};
        flag_wdata = '0;
        case (state_reg)
            ST_PAIR_WR: begin
                flag_we           = 1'b1;
                flag_wdata.in_rad = ({5'b0, d2_reg} < {1'b0, radius_reg, 4'b0} >> 4);
            end
            ST_B_CHK: begin
                flag_we           = flag_rdata.in_rad && free_pair;
                flag_wdata.in_rad = 1'b1;
                flag_wdata.pos    = 1'b1;
            end
            ST_C_FWR: begin
                flag_we           = 1'b1;
                flag_waddr        = {bj_reg, bi_reg};
                flag_wdata.in_rad = flag_rdata.in_rad;
                flag_wdata.pos    = flag_rdata.pos;
                flag_wdata.desc   = 1'b1;
                flag_wdata.rank   = rank_reg;
            end
            default: begin
                flag_we = 1'b0;
            end
        endcase
    end

    // Squarer operands
    always_comb begin
        sq_en = 1'b0;
        sq_a  = $signed(pos2_rdata[15:0]);
        sq_b  = $signed(pos1_rdata[15:0]);
        case (state_reg)
            ST_POS_X: sq_en = 1'b1;
            ST_POS_Y: begin
                sq_en = 1'b1;
                sq_a  = $signed(pos2_rdata[31:16]);
                sq_b  = $signed(pos1_rdata[31:16]);
            end
            ST_D_MUL: begin
                sq_en = 1'b1;
                sq_a  = $signed(desc1_rdata);
                sq_b  = $signed(desc2_rdata);
            end
            default: sq_en = 1'b0;
        endcase
    end

    assign sqrt_ctl.start = (state_reg == ST_R_DATA);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            nfirst_reg <= kgm_pkg::CNT_W'(1);
            nsecnd_reg <= kgm_pkg::CNT_W'(1);
            dlen_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                kgm_pkg::CFG_RADIUS: radius_reg <= cfg_wr_data;
                kgm_pkg::CFG_NFIRST: nfirst_reg <= cfg_wr_data[kgm_pkg::CNT_W-1:0];
                kgm_pkg::CFG_NSECND: nsecnd_reg <= cfg_wr_data[kgm_pkg::CNT_W-1:0];
                kgm_pkg::CFG_DLEN:   dlen_reg   <= cfg_wr_data[kgm_pkg::DLEN_W-1:0];
                default:             dlen_reg   <= dlen_reg;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            row_taken_reg <= '0;
            col_taken_reg <= '0;
            found_reg     <= 1'b0;
            rank_reg      <= '0;
            j_reg         <= '0;
            i_reg         <= '0;
        end else begin
            // Drop the result once taken, unless a new one is loaded
            if (m_axis_tready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && in_func == kgm_pkg::FUNC_COMPUTE) begin
                        nf_reg <= (nfirst_reg > kgm_pkg::CNT_W'(kgm_pkg::MAX_FEATS)) ?
                                  kgm_pkg::CNT_W'(kgm_pkg::MAX_FEATS) : nfirst_reg;
                        ns_reg <= (nsecnd_reg > kgm_pkg::CNT_W'(kgm_pkg::MAX_FEATS)) ?
                                  kgm_pkg::CNT_W'(kgm_pkg::MAX_FEATS) : nsecnd_reg;
                        nd_reg <= (dlen_reg > kgm_pkg::DLEN_W'(kgm_pkg::MAX_DESC)) ?
                                  kgm_pkg::DLEN_W'(kgm_pkg::MAX_DESC) : dlen_reg;
                        j_reg <= '0;
                        i_reg <= '0;
                        row_taken_reg  <= '0;
                        col_taken_reg  <= '0;
                        pend_done_reg  <= 1'b1;
                        pend_flags_reg <= '0;
                        pend_dist_reg  <= '0;
                        if (nfirst_reg == '0 || nsecnd_reg == '0) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_POS_A;
                        end
                    end else if (s_fire && in_func == kgm_pkg::FUNC_READ) begin
                        rd_row_reg    <= in_feat;
                        rd_col_reg    <= in_col;
                        pend_done_reg <= 1'b0;
                        state_reg     <= ST_R_ADDR;
                    end
                end
                // Pair table fill: position distance then descriptor sum
                ST_POS_A: state_reg <= ST_POS_X;
                ST_POS_X: state_reg <= ST_POS_Y;
                ST_POS_Y: begin
                    d2_reg    <= {1'b0, sq};
                    state_reg <= ST_POS_S;
                end
                ST_POS_S: begin
                    d2_reg  <= d2_reg + {1'b0, sq};
                    acc_reg <= '0;
                    v_reg   <= '0;
                    state_reg <= (nd_reg == '0) ? ST_PAIR_WR : ST_D_RD;
                end
                ST_D_RD: state_reg <= ST_D_MUL;
                ST_D_MUL: begin
                    v_reg     <= v_reg + kgm_pkg::DLEN_W'(1);
                    state_reg <= ST_D_ACC;
                end
                ST_D_ACC: begin
                    acc_reg   <= acc_reg + {{(kgm_pkg::DIST2_W-kgm_pkg::SQ_W){1'b0}}, sq};
                    state_reg <= (v_reg < nd_reg) ? ST_D_MUL : ST_PAIR_WR;
                end
                ST_PAIR_WR: begin
                    if (!last_col) begin
                        i_reg     <= i_reg + FW'(1);
                        state_reg <= ST_POS_A;
                    end else begin
                        i_reg <= '0;
                        if (!last_row) begin
                            j_reg     <= j_reg + FW'(1);
                            state_reg <= ST_POS_A;
                        end else begin
                            j_reg     <= '0;
                            state_reg <= ST_B_RD;
                        end
                    end
                end
                // Greedy position matching in scan order
                ST_B_RD: state_reg <= ST_B_CHK;
                ST_B_CHK: begin
                    if (flag_rdata.in_rad && free_pair && !(last_col && last_row)) begin
                        row_taken_reg[j_reg] <= 1'b1;
                        col_taken_reg[i_reg] <= 1'b1;
                    end
                    if (!last_col) begin
                        i_reg     <= i_reg + FW'(1);
                        state_reg <= ST_B_RD;
                    end else begin
                        i_reg <= '0;
                        if (!last_row) begin
                            j_reg     <= j_reg + FW'(1);
                            state_reg <= ST_B_RD;
                        end else begin
                            j_reg         <= '0;
                            row_taken_reg <= '0;
                            col_taken_reg <= '0;
                            found_reg     <= 1'b0;
                            rank_reg      <= '0;
                            state_reg     <= ST_C_RD;
                        end
                    end
                end
                // Greedy descriptor matching: one full scan per match
                ST_C_RD: state_reg <= ST_C_CMP;
                ST_C_CMP: begin
                    if (free_pair && (!found_reg || dist_rdata < best_reg)) begin
                        found_reg <= 1'b1;
                        best_reg  <= dist_rdata;
                        bj_reg    <= j_reg;
                        bi_reg    <= i_reg;
                    end
                    if (!last_col) begin
                        i_reg     <= i_reg + FW'(1);
                        state_reg <= ST_C_RD;
                    end else begin
                        i_reg <= '0;
                        if (!last_row) begin
                            j_reg     <= j_reg + FW'(1);
                            state_reg <= ST_C_RD;
                        end else begin
                            j_reg <= '0;
                            if (found_reg || free_pair) begin
                                state_reg <= ST_C_FRD;
                            end else begin
                                state_reg <= ST_OUT;
                            end
                        end
                    end
                end
                ST_C_FRD: state_reg <= ST_C_FWR;
                ST_C_FWR: begin
                    row_taken_reg[bj_reg] <= 1'b1;
                    col_taken_reg[bi_reg] <= 1'b1;
                    rank_reg  <= rank_reg + kgm_pkg::RANK_W'(1);
                    found_reg <= 1'b0;
                    state_reg <= ST_C_RD;
                end
                // Pair read
                ST_R_ADDR: state_reg <= ST_R_DATA;
                ST_R_DATA: begin
                    pend_flags_reg <= flag_rdata;
                    state_reg      <= ST_R_SQRT;
                end
                ST_R_SQRT: begin
                    if (sqrt_ctl.done) begin
                        pend_dist_reg <= sqrt_root;
                        state_reg     <= ST_OUT;
                    end
                end
                // Hand the result to the output register once it frees
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= pend_done_reg;
                        m_data_reg  <= pend_done_reg ? 48'd0 :
                            {7'd0, pend_flags_reg.rank, pend_flags_reg.desc,
                             pend_dist_reg, pend_flags_reg.pos, pend_flags_reg.in_rad,
                             rd_col_reg, rd_row_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Keypoint position stores
    kgm_ram #(.WIDTH(32), .DEPTH(kgm_pkg::MAX_FEATS)) u_pos1 (
        .aclk(aclk), .we(pos1_we), .waddr(in_feat), .wdata({in_y, in_x}),
        .raddr(j_reg), .rdata(pos1_rdata)
    );
    kgm_ram #(.WIDTH(32), .DEPTH(kgm_pkg::MAX_FEATS)) u_pos2 (
        .aclk(aclk), .we(pos2_we), .waddr(in_feat), .wdata({in_y, in_x}),
        .raddr(i_reg), .rdata(pos2_rdata)
    );

    // Descriptor stores
    kgm_ram #(.WIDTH(16), .DEPTH(kgm_pkg::MAX_FEATS * kgm_pkg::MAX_DESC)) u_desc1 (
        .aclk(aclk), .we(desc1_we), .waddr({in_feat, in_elem}), .wdata(in_desc),
        .raddr({j_reg, v_reg[kgm_pkg::ELEM_W-1:0]}), .rdata(desc1_rdata)
    );
    kgm_ram #(.WIDTH(16), .DEPTH(kgm_pkg::MAX_FEATS * kgm_pkg::MAX_DESC)) u_desc2 (
        .aclk(aclk), .we(desc2_we), .waddr({in_feat, in_elem}), .wdata(in_desc),
        .raddr({i_reg, v_reg[kgm_pkg::ELEM_W-1:0]}), .rdata(desc2_rdata)
    );

    // Pair table: squared descriptor sums and flags
    kgm_ram #(.WIDTH(kgm_pkg::DIST2_W), .DEPTH(kgm_pkg::MAX_FEATS * kgm_pkg::MAX_FEATS)) u_dist (
        .aclk(aclk), .we(dist_we), .waddr({j_reg, i_reg}), .wdata(acc_reg),
        .raddr(pair_raddr), .rdata(dist_rdata)
    );
    kgm_ram #(.WIDTH(kgm_pkg::FLAG_W), .DEPTH(kgm_pkg::MAX_FEATS * kgm_pkg::MAX_FEATS)) u_flag (
        .aclk(aclk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
        .raddr(pair_raddr), .rdata(flag_rdata_raw)
    );

    // Shared squarer
    kgm_sqr u_sqr (
        .aclk(aclk), .en(sq_en), .a(sq_a), .b(sq_b), .sq(sq)
    );

    // Square root for pair reads
    kgm_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_ctl.start), .value(dist_rdata),
        .done(sqrt_ctl.done), .root(sqrt_root)
    );

endmodule
